### rtl/stdsm_pkg.sv
// ----------------------------------------------------------------------------
// stdsm_pkg
// Shared widths, constants, register indexes and saturation helpers for the
// stereo tape delay with prime-tap smear.
// ----------------------------------------------------------------------------
package stdsm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int INNER_W    = 28;
    localparam int GAIN_W     = 16;
    localparam int FB_W       = 15;
    localparam int FAT_W      = 17;
    localparam int TAPS_W     = 6;
    localparam int CHASE_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int ACC_W      = 34;
    localparam int AVG_W      = 29;
    localparam int PRIME_W    = 7;
    localparam int WIDE_W     = 48;

    localparam int DELAY_DEPTH_DEF   = 65536;
    localparam int TAP_HISTORY_DEF   = 128;
    localparam int FRACTION_BITS_DEF = 23;

    localparam int CHASE_LIMIT  = 9000;
    localparam int FEEDBACK_MAX = 21299;
    localparam int FAT_FULL     = 65536;
    localparam int TAPS_MIN     = 3;
    localparam int TAPS_MAX     = 32;

    localparam logic [GAIN_W-1:0] DRY_RESET    = 16'd65535;
    localparam logic [GAIN_W-1:0] WET_RESET    = 16'd32768;
    localparam logic [GAIN_W-1:0] TARGET_RESET = 16'd22000;
    localparam logic [TAPS_W-1:0] TAPS_RESET   = 6'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DRY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUB    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 3'd6;

    localparam logic [PRIME_W-1:0] PRIME_OFFSET [0:31] = '{
        7'd1, 7'd2, 7'd3, 7'd5, 7'd7, 7'd11, 7'd13, 7'd17,
        7'd19, 7'd23, 7'd29, 7'd31, 7'd37, 7'd41, 7'd43, 7'd47,
        7'd53, 7'd59, 7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83,
        7'd89, 7'd97, 7'd101, 7'd103, 7'd107, 7'd109, 7'd113, 7'd127
    };

    localparam logic signed [WIDE_W-1:0] INNER_HI = WIDE_W'(2**(INNER_W-1) - 1);
    localparam logic signed [WIDE_W-1:0] INNER_LO = -INNER_HI - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] OUT_HI   = WIDE_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [WIDE_W-1:0] OUT_LO   = -OUT_HI - WIDE_W'(1);

    // Control strobes from the sequencer to each channel datapath.
    typedef struct packed {
        logic load_in;
        logic fb_mul;
        logic sum_calc;
        logic acc_clr;
        logic acc_add;
        logic div_start;
        logic smear_mul;
        logic store_calc;
        logic out_mul;
    } t_chan_ctl;

    function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [WIDE_W-1:0] v);
        logic signed [INNER_W-1:0] r;
        if (v > INNER_HI) begin
            r = INNER_W'(INNER_HI);
        end else if (v < INNER_LO) begin
            r = INNER_W'(INNER_LO);
        end else begin
            r = INNER_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > OUT_HI) begin
            r = SAMPLE_W'(OUT_HI);
        end else if (v < OUT_LO) begin
            r = SAMPLE_W'(OUT_LO);
        end else begin
            r = SAMPLE_W'(v);
        end
        return r;
    endfunction

endpackage

### rtl/stdsm_ram.sv
// ----------------------------------------------------------------------------
// stdsm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stdsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stdsm_div.sv
// ----------------------------------------------------------------------------
// stdsm_div
// Restoring divider, one quotient bit per cycle. Signed dividend, small
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module stdsm_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [stdsm_pkg::ACC_W-1:0]   i_dividend,
    input  logic        [stdsm_pkg::TAPS_W-1:0]  i_divisor,
    output logic signed [stdsm_pkg::ACC_W-1:0]   o_quotient,
    output logic                                 o_done
);
    import stdsm_pkg::*;

    localparam int MAG_W = ACC_W;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]  r_quo;
    logic [TAPS_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_neg;
    logic              r_done;
    logic signed [ACC_W-1:0] r_q;

    logic [TAPS_W:0]   w_rem_sh;
    logic              w_ge;
    logic [TAPS_W:0]   w_diff;
    logic [TAPS_W-1:0] n_rem;
    logic [MAG_W-1:0]  n_quo;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[MAG_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, i_divisor});
        w_diff   = w_rem_sh - {1'b0, i_divisor};
        n_rem    = w_ge ? w_diff[TAPS_W-1:0] : w_rem_sh[TAPS_W-1:0];
        n_quo    = {r_quo[MAG_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg  <= i_dividend[ACC_W-1];
                r_quo  <= i_dividend[ACC_W-1] ? MAG_W'(-i_dividend) : MAG_W'(i_dividend);
                r_rem  <= '0;
                r_cnt  <= CNT_W'(MAG_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= r_neg ? -$signed(n_quo) : $signed(n_quo);
                end
            end
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule

### rtl/stdsm_chan.sv
// ----------------------------------------------------------------------------
// stdsm_chan
// Arithmetic for one audio channel: feedback sum, tap accumulation, average,
// smear blend and the dry/wet output mix.
// ----------------------------------------------------------------------------
module stdsm_chan #(
    parameter int FRACTION_BITS = stdsm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  stdsm_pkg::t_chan_ctl                 i_ctl,
    input  logic signed [stdsm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [stdsm_pkg::INNER_W-1:0]  i_delayed,
    input  logic signed [stdsm_pkg::INNER_W-1:0]  i_hist,
    input  logic        [stdsm_pkg::FB_W-1:0]     i_fb,
    input  logic        [stdsm_pkg::FAT_W-1:0]    i_fat,
    input  logic                                  i_sub,
    input  logic        [stdsm_pkg::TAPS_W-1:0]   i_taps,
    input  logic        [stdsm_pkg::GAIN_W-1:0]   i_dry,
    input  logic        [stdsm_pkg::GAIN_W-1:0]   i_wet,
    output logic signed [stdsm_pkg::INNER_W-1:0]  o_sum,
    output logic signed [stdsm_pkg::INNER_W-1:0]  o_store,
    output logic signed [stdsm_pkg::SAMPLE_W-1:0] o_out,
    output logic                                  o_div_done
);
    import stdsm_pkg::*;

    localparam int SHIFT = SAMPLE_W - 1 - FRACTION_BITS;

    logic signed [SAMPLE_W-1:0]          r_in;
    logic signed [INNER_W+FB_W:0]        r_fbp;
    logic signed [INNER_W-1:0]           r_sum;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [AVG_W+FAT_W:0]         r_wprod;
    logic signed [INNER_W+FAT_W:0]       r_bprod;
    logic signed [INNER_W-1:0]           r_store;
    logic signed [SAMPLE_W+GAIN_W:0]     r_pd;
    logic signed [INNER_W+GAIN_W:0]      r_pw;

    logic signed [ACC_W-1:0]  w_q;
    logic signed [AVG_W-1:0]  w_avg;
    logic        [FAT_W-1:0]  w_inv;
    logic signed [WIDE_W-1:0] w_sum_wide;
    logic signed [WIDE_W-1:0] w_w;
    logic signed [WIDE_W-1:0] w_st;
    logic signed [WIDE_W-1:0] w_mix;
    logic signed [WIDE_W-1:0] w_scaled;

    stdsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (r_acc),
        .i_divisor  (i_taps),
        .o_quotient (w_q),
        .o_done     (o_div_done)
    );

    always_comb begin
        w_sum_wide = WIDE_W'(r_in) + WIDE_W'(r_fbp >>> 14);
        w_avg      = w_q[AVG_W-1:0] + AVG_W'(1);
        w_inv      = FAT_W'(FAT_FULL) - i_fat;
        w_w        = WIDE_W'(r_wprod >>> 16);
        if (i_sub) begin
            w_st = WIDE_W'(r_sum) - w_w;
        end else begin
            w_st = WIDE_W'(r_bprod >>> 16) + w_w;
        end
        w_mix    = (WIDE_W'(r_pd) + WIDE_W'(r_pw)) >>> 16;
        w_scaled = w_mix <<< SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_in <= i_sample >>> SHIFT;
        end
        if (i_ctl.fb_mul) begin
            r_fbp <= i_delayed * $signed({1'b0, i_fb});
        end
        if (i_ctl.sum_calc) begin
            r_sum <= sat_inner(w_sum_wide);
        end
        if (i_ctl.acc_clr) begin
            r_acc <= ACC_W'(r_sum);
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + ACC_W'(i_hist);
        end
        if (i_ctl.smear_mul) begin
            r_wprod <= w_avg * $signed({1'b0, i_fat});
            r_bprod <= r_sum * $signed({1'b0, w_inv});
        end
        if (i_ctl.store_calc) begin
            r_store <= sat_inner(w_st);
        end
        if (i_ctl.out_mul) begin
            r_pd <= r_in * $signed({1'b0, i_dry});
            r_pw <= i_delayed * $signed({1'b0, i_wet});
        end
    end

    assign o_sum   = r_sum;
    assign o_store = r_store;
    assign o_out   = sat_out(w_scaled);

endmodule

### rtl/stereo_tape_delay_with_prime_tap_smear_top.sv
// ----------------------------------------------------------------------------
// stereo_tape_delay_with_prime_tap_smear_top
// Stereo feedback delay line with prime-offset tap averaging and smear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one stereo frame per word.
//   Output channel (o_out_valid / i_out_ready) gives one stereo frame per
//   input word, in order. Configuration words (i_cfg_valid / o_cfg_ready,
//   index and data) are always taken and should be sent while the block is
//   idle; index 7 is ignored.
//   Each frame steps through the states feedback multiply, sum, history write,
//   N tap reads from the history RAM (one per cycle), N being the clamped tap
//   count (3 to 32), start of and wait on the 34-step serial divider, smear,
//   store, delay write (plus a second write state when the length steps),
//   move, output multiply and output. A frame is only taken while idle.
//   A new frame is taken once the previous one has reached the output
//   register, even while that result still waits for the receiver. When the
//   receiver stalls with a result pending, the next frame finishes its work
//   and holds until the output register frees.
//   After reset the block clears both RAMs over all DELAY_DEPTH addresses
//   (65536 by default), taking no frames; configuration resets to defaults.
// ----------------------------------------------------------------------------
module stereo_tape_delay_with_prime_tap_smear_top #(
    parameter int DELAY_DEPTH   = stdsm_pkg::DELAY_DEPTH_DEF,
    parameter int TAP_HISTORY   = stdsm_pkg::TAP_HISTORY_DEF,
    parameter int FRACTION_BITS = stdsm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [stdsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [stdsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [stdsm_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [stdsm_pkg::SAMPLE_W-1:0] i_right_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [stdsm_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [stdsm_pkg::SAMPLE_W-1:0] o_right_out
);
    import stdsm_pkg::*;

    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int HP_W   = $clog2(TAP_HISTORY);
    localparam int LW     = (ADDR_W > GAIN_W) ? ADDR_W : GAIN_W;
    localparam int MEM_W  = 2 * INNER_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FB_MUL, S_SUM, S_HWR, S_TAPS, S_DIV_GO, S_DIV_WAIT,
        S_SMEAR, S_STORE, S_WR1, S_WR2, S_MOVE, S_OMUL, S_OUT
    } t_state;

    t_state r_state, n_state;

    logic [GAIN_W-1:0] r_dry, r_wet, r_target;
    logic [FB_W-1:0]   r_fb;
    logic [FAT_W-1:0]  r_fat;
    logic              r_sub;
    logic [TAPS_W-1:0] r_taps;

    logic [ADDR_W-1:0]  r_wp, n_wp, r_cl, n_cl, r_clr_cnt;
    logic [CHASE_W-1:0] r_chase, n_chase;
    logic [HP_W-1:0]    r_hp, n_hp;
    logic [TAPS_W-1:0]  r_k, n_k;
    logic               r_ovalid, n_ovalid, w_load_out;
    logic signed [SAMPLE_W-1:0] r_outl, r_outr;

    logic [TAPS_W-1:0] w_taps_c;
    logic [FB_W-1:0]   w_fb_c;
    logic [FAT_W-1:0]  w_fat_c;
    logic [LW-1:0]     w_tg, w_cl_x, w_diff;
    logic [LW:0]       w_chase_sum;
    logic              w_exceed;

    logic              w_d_we, w_h_we;
    logic [ADDR_W-1:0] w_d_waddr, w_d_raddr;
    logic [MEM_W-1:0]  w_d_wdata, w_d_rdata;
    logic [HP_W-1:0]   w_h_waddr, w_h_raddr;
    logic [MEM_W-1:0]  w_h_wdata, w_h_rdata;
    logic [HP_W:0]     w_h_sum;
    logic [4:0]        w_tap_idx;

    t_chan_ctl w_ctl;
    logic signed [INNER_W-1:0]  w_sum_l, w_sum_r, w_st_l, w_st_r;
    logic signed [SAMPLE_W-1:0] w_out_l, w_out_r;
    logic                       w_done_l, w_done_r;

    // Register clamps for out-of-range settings.
    always_comb begin
        if (r_taps < TAPS_W'(TAPS_MIN)) begin
            w_taps_c = TAPS_W'(TAPS_MIN);
        end else if (r_taps > TAPS_W'(TAPS_MAX)) begin
            w_taps_c = TAPS_W'(TAPS_MAX);
        end else begin
            w_taps_c = r_taps;
        end
        w_fb_c  = (r_fb > FB_W'(FEEDBACK_MAX)) ? FB_W'(FEEDBACK_MAX) : r_fb;
        w_fat_c = (r_fat > FAT_W'(FAT_FULL)) ? FAT_W'(FAT_FULL) : r_fat;
        w_tg    = (LW'(r_target) > LW'(DELAY_DEPTH - 1)) ? LW'(DELAY_DEPTH - 1)
                                                         : LW'(r_target);
        w_cl_x  = LW'(r_cl);
        w_diff  = (w_cl_x > w_tg) ? (w_cl_x - w_tg) : (w_tg - w_cl_x);
        w_chase_sum = (LW+1)'(r_chase) + (LW+1)'(w_diff);
        w_exceed    = (w_chase_sum > (LW+1)'(CHASE_LIMIT));
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_cl     = r_cl;
        n_chase  = r_chase;
        n_hp     = r_hp;
        n_k      = r_k;
        n_ovalid = r_ovalid;
        w_load_out = 1'b0;
        w_ctl    = '0;
        w_d_we   = 1'b0;
        w_h_we   = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_d_we = 1'b1;
                w_h_we = (r_clr_cnt < ADDR_W'(TAP_HISTORY));
                if (r_clr_cnt == ADDR_W'(DELAY_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.load_in = 1'b1;
                    n_state = S_FB_MUL;
                end
            end
            S_FB_MUL: begin
                w_ctl.fb_mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                w_ctl.sum_calc = 1'b1;
                n_state = S_HWR;
            end
            S_HWR: begin
                w_h_we = 1'b1;
                w_ctl.acc_clr = 1'b1;
                n_k = TAPS_W'(1);
                n_state = S_TAPS;
            end
            S_TAPS: begin
                w_ctl.acc_add = 1'b1;
                if (r_k == w_taps_c) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_k = r_k + TAPS_W'(1);
                end
            end
            S_DIV_GO: begin
                w_ctl.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_done_l && w_done_r) begin
                    n_state = S_SMEAR;
                end
            end
            S_SMEAR: begin
                w_ctl.smear_mul = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                w_ctl.store_calc = 1'b1;
                n_state = S_WR1;
            end
            S_WR1: begin
                if (w_exceed) begin
                    n_chase = '0;
                    if (w_cl_x > w_tg) begin
                        // Shrink: write here, step back one and write again.
                        w_d_we  = 1'b1;
                        n_cl    = r_cl - ADDR_W'(1);
                        n_wp    = (r_wp == '0) ? (r_cl - ADDR_W'(1)) : (r_wp - ADDR_W'(1));
                        n_state = S_WR2;
                    end else if (w_cl_x < w_tg) begin
                        n_cl    = r_cl + ADDR_W'(1);
                        n_wp    = r_wp + ADDR_W'(1);
                        n_state = S_WR2;
                    end else begin
                        n_state = S_MOVE;
                    end
                end else begin
                    w_d_we  = 1'b1;
                    n_chase = w_chase_sum[CHASE_W-1:0];
                    n_state = S_MOVE;
                end
            end
            S_WR2: begin
                w_d_we  = 1'b1;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                n_hp = (r_hp == '0) ? HP_W'(TAP_HISTORY - 1) : (r_hp - HP_W'(1));
                n_wp = (r_wp == '0) ? r_cl : (r_wp - ADDR_W'(1));
                n_state = S_OMUL;
            end
            S_OMUL: begin
                w_ctl.out_mul = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory addressing.
    always_comb begin
        w_tap_idx = (r_state == S_TAPS) ? r_k[4:0] : 5'd0;
        w_h_sum   = (HP_W+1)'(r_hp) + (HP_W+1)'(PRIME_OFFSET[w_tap_idx]);
        if (w_h_sum >= (HP_W+1)'(TAP_HISTORY)) begin
            w_h_sum = w_h_sum - (HP_W+1)'(TAP_HISTORY);
        end
        w_h_raddr = w_h_sum[HP_W-1:0];
        w_h_waddr = (r_state == S_CLEAR) ? r_clr_cnt[HP_W-1:0] : r_hp;
        w_h_wdata = (r_state == S_CLEAR) ? '0 : {w_sum_l, w_sum_r};
        w_d_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_wp;
        w_d_wdata = (r_state == S_CLEAR) ? '0 : {w_st_l, w_st_r};
        w_d_raddr = (r_state == S_MOVE) ? n_wp : r_wp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_wp      <= '0;
            r_cl      <= '0;
            r_chase   <= '0;
            r_hp      <= '0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
            r_dry     <= DRY_RESET;
            r_wet     <= WET_RESET;
            r_target  <= TARGET_RESET;
            r_fb      <= '0;
            r_fat     <= '0;
            r_sub     <= 1'b0;
            r_taps    <= TAPS_RESET;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_cl     <= n_cl;
            r_chase  <= n_chase;
            r_hp     <= n_hp;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DRY:    r_dry    <= i_cfg_data[GAIN_W-1:0];
                    REG_WET:    r_wet    <= i_cfg_data[GAIN_W-1:0];
                    REG_TARGET: r_target <= i_cfg_data[GAIN_W-1:0];
                    REG_FB:     r_fb     <= i_cfg_data[FB_W-1:0];
                    REG_FAT:    r_fat    <= i_cfg_data[FAT_W-1:0];
                    REG_SUB:    r_sub    <= i_cfg_data[0];
                    REG_TAPS:   r_taps   <= i_cfg_data[TAPS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        if (w_load_out) begin
            r_outl <= w_out_l;
            r_outr <= w_out_r;
        end
    end

    stdsm_ram #(.WIDTH(MEM_W), .DEPTH(DELAY_DEPTH)) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    stdsm_ram #(.WIDTH(MEM_W), .DEPTH(TAP_HISTORY)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (w_h_waddr),
        .i_wdata (w_h_wdata),
        .i_raddr (w_h_raddr),
        .o_rdata (w_h_rdata)
    );

    stdsm_chan #(.FRACTION_BITS(FRACTION_BITS)) u_chan_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sample   (i_left_sample),
        .i_delayed  ($signed(w_d_rdata[MEM_W-1:INNER_W])),
        .i_hist     ($signed(w_h_rdata[MEM_W-1:INNER_W])),
        .i_fb       (w_fb_c),
        .i_fat      (w_fat_c),
        .i_sub      (r_sub),
        .i_taps     (w_taps_c),
        .i_dry      (r_dry),
        .i_wet      (r_wet),
        .o_sum      (w_sum_l),
        .o_store    (w_st_l),
        .o_out      (w_out_l),
        .o_div_done (w_done_l)
    );

    stdsm_chan #(.FRACTION_BITS(FRACTION_BITS)) u_chan_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sample   (i_right_sample),
        .i_delayed  ($signed(w_d_rdata[INNER_W-1:0])),
        .i_hist     ($signed(w_h_rdata[INNER_W-1:0])),
        .i_fb       (w_fb_c),
        .i_fat      (w_fat_c),
        .i_sub      (r_sub),
        .i_taps     (w_taps_c),
        .i_dry      (r_dry),
        .i_wet      (r_wet),
        .o_sum      (w_sum_r),
        .o_store    (w_st_r),
        .o_out      (w_out_r),
        .o_div_done (w_done_r)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_left_out  = r_outl;
    assign o_right_out = r_outr;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Stereo tape delay testbench
// Drives directed and random stereo frames in bursts, stalls the output side, and
// checks every output frame against a cycle-free predictor of the delay line, the
// prime-tap smear and the length chase, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import stdsm_pkg::*;

    localparam int DEPTH    = DELAY_DEPTH_DEF;
    localparam int HIST     = TAP_HISTORY_DEF;
    localparam int DRAIN    = 200;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_frame;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [SAMPLE_W-1:0] i_right_sample = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid;
    logic signed [SAMPLE_W-1:0] o_left_out, o_right_out;

    stereo_tape_delay_with_prime_tap_smear_top dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state.
    logic [GAIN_W-1:0] dry_g, wet_g, target_len;
    logic [FB_W-1:0] fb_g;
    logic [FAT_W-1:0] fat_amt;
    logic lean_mode;
    logic [TAPS_W-1:0] tap_cnt;
    logic signed [INNER_W-1:0] line_l [DEPTH];
    logic signed [INNER_W-1:0] line_r [DEPTH];
    longint hist_l [HIST];
    longint hist_r [HIST];
    int unsigned wpos, cur_len, chase_acc, hpos;

    t_frame pending_frames[$];
    t_frame expected_out[$];
    int unsigned errors = 0;
    longint cycles = 0;

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat(longint v, int bits);
        longint hi = (longint'(1) << (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint smear_store(longint x, longint delayed, ref longint h[HIST],
                                           input int taps, longint fb, longint fat,
                                           int unsigned hp);
        longint s, total, avg, w, st;
        s = sat(x + fl_shift(delayed * fb, 14), INNER_W);
        h[hp] = s;
        total = s;
        for (int k = 0; k < taps; k++) total += h[(hp + PRIME_OFFSET[k]) % HIST];
        avg = total / taps + 1;
        w = fl_shift(avg * fat, 16);
        if (lean_mode) st = s - w;
        else st = fl_shift(s * (FAT_FULL - fat), 16) + w;
        return sat(st, INNER_W);
    endfunction

    task automatic write_line(int unsigned p, longint l, longint r);
        line_l[p] = l[INNER_W-1:0];
        line_r[p] = r[INNER_W-1:0];
    endtask

    function automatic logic signed [SAMPLE_W-1:0] mix_out(longint x, longint d);
        return SAMPLE_W'(sat(sat(fl_shift(x * dry_g + d * wet_g, 16), INNER_W + 8), SAMPLE_W));
    endfunction

    task automatic predict_frame(t_frame f);
        int taps;
        longint fb, fat, st_l, st_r;
        int unsigned tgt, diff;
        t_frame r;
        taps = tap_cnt < TAPS_MIN ? TAPS_MIN : (tap_cnt > TAPS_MAX ? TAPS_MAX : tap_cnt);
        fb = fb_g > FEEDBACK_MAX ? FEEDBACK_MAX : fb_g;
        fat = fat_amt > FAT_FULL ? FAT_FULL : fat_amt;
        tgt = target_len > DEPTH - 1 ? DEPTH - 1 : target_len;
        if (wpos > cur_len) wpos = cur_len;
        st_l = smear_store(f.left, line_l[wpos], hist_l, taps, fb, fat, hpos);
        st_r = smear_store(f.right, line_r[wpos], hist_r, taps, fb, fat, hpos);
        diff = cur_len > tgt ? cur_len - tgt : tgt - cur_len;
        chase_acc += diff;
        if (chase_acc > CHASE_LIMIT) begin
            if (cur_len > tgt) begin
                write_line(wpos, st_l, st_r);
                cur_len--;
                wpos = wpos == 0 ? cur_len : wpos - 1;
                write_line(wpos, st_l, st_r);
            end
            if (cur_len < tgt) begin
                cur_len++;
                wpos++;
                if (wpos > cur_len) wpos = 0;
                write_line(wpos, st_l, st_r);
            end
            chase_acc = 0;
        end else begin
            write_line(wpos, st_l, st_r);
        end
        hpos = hpos == 0 ? HIST - 1 : hpos - 1;
        wpos = wpos == 0 ? cur_len : wpos - 1;
        if (wpos > cur_len) wpos = cur_len;
        r.left = mix_out(f.left, line_l[wpos]);
        r.right = mix_out(f.right, line_r[wpos]);
        expected_out.push_back(r);
    endtask

    task automatic report(string what, logic signed [SAMPLE_W-1:0] got,
                          logic signed [SAMPLE_W-1:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // Driver: bursts of words with random gaps.
    int unsigned burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_in_valid && o_in_ready) predict_frame({i_left_sample, i_right_sample});
        if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_frames.size() > 0) begin
                t_frame f;
                f = pending_frames.pop_front();
                i_in_valid <= 1'b1;
                i_left_sample <= f.left;
                i_right_sample <= f.right;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern and monitor.
    int unsigned stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9]) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0) && !(stall_phase[6:4] == 3'd5);
        if (o_out_valid && i_out_ready) begin
            if (expected_out.size() == 0) begin
                errors++;
                $display("unexpected output word at cycle %0d", cycles);
            end else begin
                t_frame e;
                e = expected_out.pop_front();
                if (o_left_out !== e.left) report("left", o_left_out, e.left);
                if (o_right_out !== e.right) report("right", o_right_out, e.right);
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_DRY:    dry_g = val[GAIN_W-1:0];
            REG_WET:    wet_g = val[GAIN_W-1:0];
            REG_TARGET: target_len = val[GAIN_W-1:0];
            REG_FB:     fb_g = val[FB_W-1:0];
            REG_FAT:    fat_amt = val;
            REG_SUB:    lean_mode = val[0];
            REG_TAPS:   tap_cnt = val[TAPS_W-1:0];
            default: ;
        endcase
    endtask

    // Sampled mid-cycle so the driver's pop and valid update are both settled.
    task automatic wait_idle();
        while (pending_frames.size() > 0 || i_in_valid || expected_out.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rnd_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return SAMPLE_W'($urandom_range(0, 255)) - 24'sd128;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_random(int n);
        t_frame f;
        repeat (n) begin
            f.left = rnd_sample();
            f.right = rnd_sample();
            pending_frames.push_back(f);
        end
    endtask

    initial begin
        t_frame f;
        dry_g = DRY_RESET; wet_g = WET_RESET; target_len = TARGET_RESET;
        fb_g = '0; fat_amt = '0; lean_mode = 1'b0; tap_cnt = TAPS_RESET;
        foreach (line_l[k]) begin line_l[k] = '0; line_r[k] = '0; end
        foreach (hist_l[k]) begin hist_l[k] = 0; hist_r[k] = 0; end
        wpos = 0; cur_len = 0; chase_acc = 0; hpos = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short delay so echoes return quickly; maximal feedback and fat.
        cfg_write(REG_TARGET, 17'd40);
        cfg_write(REG_FB, 17'd21299);
        cfg_write(REG_FAT, 17'd65536);
        cfg_write(REG_TAPS, 17'd32);
        cfg_write(REG_WET, 17'd65535);
        // Directed extremes.
        f = '{24'sh7FFFFF, 24'sh800000}; repeat (4) pending_frames.push_back(f);
        f = '{24'sh800000, 24'sh7FFFFF}; repeat (4) pending_frames.push_back(f);
        f = '{24'sh000000, 24'shFFFFFF}; repeat (4) pending_frames.push_back(f);
        f = '{24'sh555555, 24'shAAAAAA}; repeat (4) pending_frames.push_back(f);
        wait_idle();

        // Lean mode, out-of-range tap count and overlarge feedback and fat.
        cfg_write(REG_SUB, 17'd1);
        cfg_write(REG_TAPS, 17'd63);
        cfg_write(REG_FB, 17'h7FFF);
        cfg_write(REG_FAT, 17'h1FFFF);
        cfg_write(3'd7, 17'h1FFFF);
        f = '{24'sh7FFFFF, 24'sh7FFFFF}; repeat (3) pending_frames.push_back(f);
        add_random(150);
        wait_idle();

        // Low tap count, zero gains, target length lowered from 40 to 3.
        cfg_write(REG_TAPS, 17'd0);
        cfg_write(REG_DRY, 17'd0);
        cfg_write(REG_WET, 17'd0);
        cfg_write(REG_TARGET, 17'd3);
        cfg_write(REG_SUB, 17'd0);
        cfg_write(REG_FAT, 17'd20000);
        add_random(120);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            cfg_write(REG_DRY, 17'($urandom_range(0, 65535)));
            cfg_write(REG_WET, 17'($urandom_range(0, 65535)));
            cfg_write(REG_TARGET, 17'(ph == 4 ? 65535 : $urandom_range(0, 200)));
            cfg_write(REG_FB, 17'($urandom_range(0, 21299)));
            cfg_write(REG_FAT, 17'($urandom_range(0, 65536)));
            cfg_write(REG_SUB, 17'($urandom_range(0, 1)));
            cfg_write(REG_TAPS, 17'($urandom_range(3, 32)));
            add_random(130);
            wait_idle();
        end

        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
